FILE: hw/rtl/spn_enc16_pkg.sv
// Shared constants and round functions for the 16-bit SPN block cipher.
package spn_enc16_pkg;

  // Block and key geometry
  localparam int unsigned BLOCK_W   = 16;
  localparam int unsigned NIBBLES   = BLOCK_W / 4;
  localparam int unsigned ROUNDS    = 4;
  localparam int unsigned KEY_COUNT = 4;
  localparam int unsigned KEY_SEL_W = $clog2(KEY_COUNT);
  localparam int unsigned CFG_IDX_W = 8;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef block_t [KEY_COUNT-1:0] key_set_t;

  // Every round key comes out of reset as one
  localparam block_t KEY_RESET = block_t'(1);

  // 4-bit substitution box
  function automatic logic [3:0] sbox(input logic [3:0] nib);
    logic [3:0] res;
    case (nib)
      4'h0: res = 4'h4;
      4'h1: res = 4'h3;
      4'h2: res = 4'h6;
      4'h3: res = 4'h2;
      4'h4: res = 4'hF;
      4'h5: res = 4'h5;
      4'h6: res = 4'h8;
      4'h7: res = 4'h9;
      4'h8: res = 4'hD;
      4'h9: res = 4'hE;
      4'hA: res = 4'hC;
      4'hB: res = 4'hB;
      4'hC: res = 4'hA;
      4'hD: res = 4'h1;
      4'hE: res = 4'h0;
      default: res = 4'h7;
    endcase
    return res;
  endfunction

  // Destination bit of each source bit in the permutation layer
  function automatic logic [3:0] perm_dest(input logic [3:0] src);
    logic [3:0] res;
    case (src)
      4'd0:  res = 4'd15;
      4'd1:  res = 4'd2;
      4'd2:  res = 4'd11;
      4'd3:  res = 4'd4;
      4'd4:  res = 4'd9;
      4'd5:  res = 4'd0;
      4'd6:  res = 4'd7;
      4'd7:  res = 4'd8;
      4'd8:  res = 4'd6;
      4'd9:  res = 4'd10;
      4'd10: res = 4'd1;
      4'd11: res = 4'd12;
      4'd12: res = 4'd14;
      4'd13: res = 4'd3;
      4'd14: res = 4'd13;
      default: res = 4'd5;
    endcase
    return res;
  endfunction

endpackage

FILE: hw/rtl/spn_block_encrypt16_top.sv
// Top level of the 16-bit SPN block cipher: key registers, round chain, handshake.
//
// Each plaintext transaction is latched into an input register, runs through
// key whitening and three combinational rounds, and lands in the result
// register; one block can be accepted every cycle unless both slots are full
// and out_ready_i is low. The input register is a second slot: while a
// ciphertext waits for out_ready_i, one more plaintext is taken and held.
// Round keys are written through cfg_we_i / cfg_idx_i / cfg_wdata_i (index 0
// to 3, other indexes ignored), reset to 1, and must only be changed while
// no block is in flight.
module spn_block_encrypt16_top
  import spn_enc16_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BLOCK_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [BLOCK_W-1:0]   plaintext_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BLOCK_W-1:0]   ciphertext_o
);

  key_set_t keys;

  logic   in_valid_q;
  block_t in_data_q;
  logic   out_valid_q;
  block_t out_data_q;
  logic   advance;

  block_t stage [ROUNDS];

  spn_enc16_keys u_keys (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .keys_o      (keys)
  );

  // Whitening, then the round chain; key index saturates at the last key
  assign stage[0] = in_data_q ^ keys[0];

  for (genvar r = 1; r < ROUNDS; r++) begin : g_round
    localparam int unsigned KeySel = (r < KEY_COUNT) ? r : KEY_COUNT - 1;
    spn_enc16_round u_round (
      .data_i (stage[r-1]),
      .key_i  (keys[KeySel]),
      .data_o (stage[r])
    );
  end

  // Move the input slot forward when the result slot is free or draining
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= plaintext_i;
    end
    if (advance && in_valid_q) begin
      out_data_q <= stage[ROUNDS-1];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ciphertext_o = out_data_q;

  // A block in the input slot reaches the output in the cycle after it moves
  a_input_reaches_output : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && advance) |=> out_valid_q
  ) else $error("queued block did not reach the result register");

  // Never accept while both slots are full and the output is stalled
  a_no_overrun : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o
  ) else $error("input accepted while both slots are occupied");

  // Loaded ciphertext matches the round chain output of the previous cycle
  a_result_load : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && advance) |=> (ciphertext_o == $past(stage[ROUNDS-1]))
  ) else $error("result register not loaded from the round chain");

endmodule

FILE: hw/rtl/spn_enc16_keys.sv
// Round key register file written through the configuration port.
module spn_enc16_keys
  import spn_enc16_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BLOCK_W-1:0]   cfg_wdata_i,
  output key_set_t             keys_o
);

  key_set_t key_q;

  // Load the addressed key; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < KEY_COUNT; i++) begin
        key_q[i] <= KEY_RESET;
      end
    end else if (cfg_we_i) begin
      for (int unsigned i = 0; i < KEY_COUNT; i++) begin
        if (cfg_idx_i == CFG_IDX_W'(i)) begin
          key_q[i] <= cfg_wdata_i;
        end
      end
    end
  end

  assign keys_o = key_q;

endmodule

FILE: hw/rtl/spn_enc16_round.sv
// One cipher round: S-box on every nibble, bit permutation, key mix.
module spn_enc16_round
  import spn_enc16_pkg::*;
(
  input  block_t data_i,
  input  block_t key_i,
  output block_t data_o
);

  block_t sub;
  block_t perm;

  // Substitute each nibble
  always_comb begin
    for (int unsigned n = 0; n < NIBBLES; n++) begin
      sub[4*n +: 4] = sbox(data_i[4*n +: 4]);
    end
  end

  // Scatter each bit to its destination
  always_comb begin
    perm = '0;
    for (int unsigned b = 0; b < BLOCK_W; b++) begin
      perm[perm_dest(4'(b))] = sub[b];
    end
  end

  assign data_o = perm ^ key_i;

endmodule
